/* src/triangle_unit_normal_core_assert.svh */
// Assertion macros shared by the unit normal core RTL.
// Depends on a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef TRIANGLE_UNIT_NORMAL_CORE_ASSERT_SVH
`define TRIANGLE_UNIT_NORMAL_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TUN_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("tun assertion failed");
`define TUN_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tun assertion failed");
`else
`define TUN_ASSERT_ALWAYS(lbl, expr)
`define TUN_ASSERT_IMPLY(lbl, ante, cons)
`endif
`endif

/* src/tun_pkg.sv */
// Shared types and constants for the triangle unit normal core.
// No dependencies.
package tun_pkg;
  localparam int OUT_W = 32;
  localparam int LANES = 3;

  typedef struct packed {
    logic             valid;
    logic             degenerate;
    logic [LANES-1:0] neg;
  } ctrl_t;
endpackage

/* src/tun_isqrt.sv */
// Pipelined integer square root, one root bit per register stage.
// Depends on tun_pkg for the control word carried alongside.
module tun_isqrt #(
  parameter int XW = 130,
  parameter int AW = 102
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [XW-1:0]      x,
  input  logic [AW-1:0]      aux_in,
  input  tun_pkg::ctrl_t     ctrl_in,
  output logic [XW/2-1:0]    root,
  output logic [AW-1:0]      aux_out,
  output tun_pkg::ctrl_t     ctrl_out
);
  import tun_pkg::*;

  localparam int RW = XW / 2;

  logic [RW:0]    rem_q  [0:RW-2];
  logic [XW-1:0]  x_q    [0:RW-2];
  logic [RW-1:0]  root_q [0:RW-1];
  logic [AW-1:0]  aux_q  [0:RW-1];
  ctrl_t          ctrl_q [0:RW-1];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW:0]   rem_in;
    logic [RW-1:0] root_in;
    logic [XW-1:0] x_in;
    logic [AW-1:0] aux_i;
    ctrl_t         ctrl_i;
    logic [RW+2:0] cur;
    logic [RW+2:0] trial;
    logic [RW+2:0] diff;
    logic          fit;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x;
      assign aux_i   = aux_in;
      assign ctrl_i  = ctrl_in;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign x_in    = x_q[k-1];
      assign aux_i   = aux_q[k-1];
      assign ctrl_i  = ctrl_q[k-1];
    end

    // bring down the next bit pair and try the new root bit
    assign cur   = {rem_in, x_in[XW-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign diff  = cur - trial;
    assign fit   = (cur >= trial);

    always_ff @(posedge clk) begin
      root_q[k] <= {root_in[RW-2:0], fit};
      aux_q[k]  <= aux_i;
    end

    if (k < RW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_q[k] <= fit ? diff[RW:0] : cur[RW:0];
        x_q[k]   <= x_in << 2;
      end
    end

    // advance the control word, valid cleared at reset
    always_ff @(posedge clk) begin
      if (rst) begin
        ctrl_q[k] <= '0;
      end else begin
        ctrl_q[k] <= ctrl_i;
      end
    end
  end

  assign root     = root_q[RW-1];
  assign aux_out  = aux_q[RW-1];
  assign ctrl_out = ctrl_q[RW-1];
endmodule

/* src/tun_div.sv */
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit a stage.
// Depends on tun_pkg for the control word and lane count.
module tun_div #(
  parameter int RW  = 65,
  parameter int MW  = 34,
  parameter int FRB = 30
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [tun_pkg::LANES-1:0][MW-1:0] mag_in,
  input  logic [RW-1:0]                     r_in,
  input  tun_pkg::ctrl_t                    ctrl_in,
  output logic [tun_pkg::LANES-1:0][FRB:0]  quot,
  output tun_pkg::ctrl_t                    ctrl_out
);
  import tun_pkg::*;

  localparam int NS = FRB + 1;

  logic [LANES-1:0][RW-1:0] p_q [0:NS-2];
  logic [RW-1:0]            r_q [0:NS-2];
  logic [LANES-1:0][FRB:0]  q_q [0:NS-1];
  ctrl_t                    ctrl_q [0:NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [LANES-1:0][RW-1:0] p_in;
    logic [LANES-1:0][FRB:0]  q_in;
    logic [RW-1:0]            r_i;
    ctrl_t                    ctrl_i;
    logic [LANES-1:0][RW-1:0] p_nx;
    logic [LANES-1:0][FRB:0]  q_nx;

    if (k == 0) begin : g_first
      for (genvar j = 0; j < LANES; j++) begin : g_init
        // partial remainder starts as |n| * 2^(F-1), below the divisor
        assign p_in[j] = RW'(mag_in[j]) << (FRB - 1);
      end
      assign q_in   = '0;
      assign r_i    = r_in;
      assign ctrl_i = ctrl_in;
    end else begin : g_next
      assign p_in   = p_q[k-1];
      assign q_in   = q_q[k-1];
      assign r_i    = r_q[k-1];
      assign ctrl_i = ctrl_q[k-1];
    end

    for (genvar j = 0; j < LANES; j++) begin : g_lane
      logic [RW:0] t;
      logic [RW:0] d;
      logic        fit;
      // shift in a zero dividend bit and subtract where the divisor fits
      assign t   = {p_in[j], 1'b0};
      assign d   = t - {1'b0, r_i};
      assign fit = (t >= {1'b0, r_i});
      assign p_nx[j] = fit ? d[RW-1:0] : t[RW-1:0];
      assign q_nx[j] = {q_in[j][FRB-1:0], fit};
    end

    always_ff @(posedge clk) begin
      q_q[k] <= q_nx;
    end

    if (k < NS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        p_q[k] <= p_nx;
        r_q[k] <= r_i;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctrl_q[k] <= '0;
      end else begin
        ctrl_q[k] <= ctrl_i;
      end
    end
  end

  assign quot     = q_q[NS-1];
  assign ctrl_out = ctrl_q[NS-1];
endmodule

/* src/triangle_unit_normal_core.sv */
// Triangle unit normal core: top level, front end arithmetic and output register.
// Depends on tun_pkg, tun_isqrt, tun_div and triangle_unit_normal_core_assert.svh.
//
// Usage
//   Drive the nine corner coordinates and pulse start; a word is taken at every
//   clock edge with start high and busy low. busy is held low, so one triangle
//   may enter on every cycle with no gaps.
//   Each word gives exactly one result, shown on normal_x/y/z and degenerate for
//   one cycle with done high. The receiver cannot hold results off.
//   The pipeline has five front stages (difference, products, cross, squares,
//   sum), RW square root stages, FRAC_BITS+1 divider stages and the output
//   register, RW being half the padded width of S * 2^(2*FRAC_BITS).
//   Throughput is one triangle per cycle; each pipeline stage holds one word.
//   Collinear corners give zero components with degenerate set.
//   Reset clears every valid bit in the pipeline; words in flight are dropped.
module triangle_unit_normal_core #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 30
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COORD_WIDTH-1:0]     a_x,
  input  logic signed [COORD_WIDTH-1:0]     a_y,
  input  logic signed [COORD_WIDTH-1:0]     a_z,
  input  logic signed [COORD_WIDTH-1:0]     b_x,
  input  logic signed [COORD_WIDTH-1:0]     b_y,
  input  logic signed [COORD_WIDTH-1:0]     b_z,
  input  logic signed [COORD_WIDTH-1:0]     c_x,
  input  logic signed [COORD_WIDTH-1:0]     c_y,
  input  logic signed [COORD_WIDTH-1:0]     c_z,
  output logic                              done,
  output logic signed [tun_pkg::OUT_W-1:0]  normal_x,
  output logic signed [tun_pkg::OUT_W-1:0]  normal_y,
  output logic signed [tun_pkg::OUT_W-1:0]  normal_z,
  output logic                              degenerate
);
  import tun_pkg::*;

  `include "triangle_unit_normal_core_assert.svh"

  localparam int DW  = COORD_WIDTH + 1;
  localparam int PW  = 2 * DW;
  localparam int NW  = PW + 1;
  localparam int MW  = PW;
  localparam int SQW = 2 * MW;
  localparam int SW  = SQW + 2;
  localparam int XW0 = SW + 2 * FRAC_BITS;
  localparam int XW  = XW0 + (XW0 % 2);
  localparam int RW  = XW / 2;

  assign busy = 1'b0;

  // stage 1: edge vectors
  logic              v1;
  logic signed [DW-1:0] sx, sy, sz, tx, ty, tz;
  always_ff @(posedge clk) begin
    sx <= DW'(a_x) - DW'(b_x);
    sy <= DW'(a_y) - DW'(b_y);
    sz <= DW'(a_z) - DW'(b_z);
    tx <= DW'(c_x) - DW'(b_x);
    ty <= DW'(c_y) - DW'(b_y);
    tz <= DW'(c_z) - DW'(b_z);
  end

  // stage 2: the six cross products
  logic              v2;
  logic signed [PW-1:0] p_ysz, p_zsy, p_zsx, p_xsz, p_xsy, p_ysx;
  always_ff @(posedge clk) begin
    p_ysz <= PW'(ty) * PW'(sz);
    p_zsy <= PW'(tz) * PW'(sy);
    p_zsx <= PW'(tz) * PW'(sx);
    p_xsz <= PW'(tx) * PW'(sz);
    p_xsy <= PW'(tx) * PW'(sy);
    p_ysx <= PW'(ty) * PW'(sx);
  end

  // stage 3: normal components as sign and magnitude
  logic              v3;
  logic signed [NW-1:0] nx_c, ny_c, nz_c;
  logic [NW-1:0]     ax_c, ay_c, az_c;
  logic [LANES-1:0]  neg3;
  logic [LANES-1:0][MW-1:0] mag3;
  assign nx_c = NW'(p_ysz) - NW'(p_zsy);
  assign ny_c = NW'(p_zsx) - NW'(p_xsz);
  assign nz_c = NW'(p_xsy) - NW'(p_ysx);
  assign ax_c = nx_c[NW-1] ? NW'(-nx_c) : NW'(nx_c);
  assign ay_c = ny_c[NW-1] ? NW'(-ny_c) : NW'(ny_c);
  assign az_c = nz_c[NW-1] ? NW'(-nz_c) : NW'(nz_c);
  always_ff @(posedge clk) begin
    neg3    <= {nz_c[NW-1], ny_c[NW-1], nx_c[NW-1]};
    mag3[0] <= ax_c[MW-1:0];
    mag3[1] <= ay_c[MW-1:0];
    mag3[2] <= az_c[MW-1:0];
  end

  // stage 4: squares
  logic              v4;
  logic [LANES-1:0]  neg4;
  logic [LANES-1:0][MW-1:0] mag4;
  logic [LANES-1:0][SQW-1:0] sq4;
  always_ff @(posedge clk) begin
    neg4 <= neg3;
    mag4 <= mag3;
    for (int j = 0; j < LANES; j++) begin
      sq4[j] <= SQW'(mag3[j]) * SQW'(mag3[j]);
    end
  end

  // stage 5: squared length and degenerate flag
  logic [SW-1:0]     sum5;
  logic [LANES-1:0]  neg5;
  logic [LANES-1:0][MW-1:0] mag5;
  ctrl_t             ctrl5;
  always_ff @(posedge clk) begin
    sum5 <= SW'(sq4[0]) + SW'(sq4[1]) + SW'(sq4[2]);
    neg5 <= neg4;
    mag5 <= mag4;
  end

  // advance front end valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  logic v5;
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
  end

  assign ctrl5.valid      = v5;
  assign ctrl5.degenerate = (sum5 == '0);
  assign ctrl5.neg        = neg5;

  // square root of S * 2^(2F)
  logic [XW-1:0]     x5;
  logic [RW-1:0]     root;
  logic [LANES*MW-1:0] aux_sq;
  ctrl_t             ctrl_sq;
  assign x5 = XW'(sum5) << (2 * FRAC_BITS);

  tun_isqrt #(
    .XW (XW),
    .AW (LANES * MW)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .x        (x5),
    .aux_in   (mag5),
    .ctrl_in  (ctrl5),
    .root     (root),
    .aux_out  (aux_sq),
    .ctrl_out (ctrl_sq)
  );

  // scale each component by 2^(2F) / r
  logic [LANES-1:0][FRAC_BITS:0] quot;
  ctrl_t             ctrl_dv;

  tun_div #(
    .RW  (RW),
    .MW  (MW),
    .FRB (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .mag_in   (aux_sq),
    .r_in     (root),
    .ctrl_in  (ctrl_sq),
    .quot     (quot),
    .ctrl_out (ctrl_dv)
  );

  // output register: apply signs, force zeros for degenerate words
  logic [LANES-1:0][OUT_W-1:0] comp;
  for (genvar j = 0; j < LANES; j++) begin : g_sign
    assign comp[j] = ctrl_dv.degenerate ? '0 :
                     ctrl_dv.neg[j] ? OUT_W'(-OUT_W'(quot[j])) : OUT_W'(quot[j]);
  end

  always_ff @(posedge clk) begin
    normal_x   <= comp[0];
    normal_y   <= comp[1];
    normal_z   <= comp[2];
    degenerate <= ctrl_dv.degenerate;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl_dv.valid;
    end
  end

  `TUN_ASSERT_IMPLY(a_degen_zero, done && degenerate,
    normal_x == '0 && normal_y == '0 && normal_z == '0)
  `TUN_ASSERT_IMPLY(a_unit_nonzero, done && !degenerate,
    normal_x != '0 || normal_y != '0 || normal_z != '0)
  `TUN_ASSERT_IMPLY(a_range_x, done && !degenerate,
    normal_x <= $signed(OUT_W'(1) << FRAC_BITS) && normal_x >= -$signed(OUT_W'(1) << FRAC_BITS))
  `TUN_ASSERT_ALWAYS(a_never_busy, !busy)
endmodule
